>>> rtl/core/turing_machine_step_engine_top_defines.svh
// assertion macros for the step engine
`ifndef TURING_MACHINE_STEP_ENGINE_TOP_DEFINES_SVH
`define TURING_MACHINE_STEP_ENGINE_TOP_DEFINES_SVH
`define TM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/core/tmse_pkg.sv
// ---------------------------------------------------------------------------
// tmse_pkg
// types and constants shared by the turing machine step engine
// ---------------------------------------------------------------------------
package tmse_pkg;
	localparam int TAPE_CELLS = 4096;
	localparam int RULE_SLOTS = 256;
	localparam int STATE_COUNT = 256;
	localparam int TAPE_AW = $clog2(TAPE_CELLS);
	localparam int RULE_AW = $clog2(RULE_SLOTS);
	localparam logic [TAPE_AW-1:0] TAPE_MID = TAPE_AW'(TAPE_CELLS / 2);
	localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);

	typedef enum logic [2:0] {
		FN_CLEAR = 3'd0, FN_ADD_RULE = 3'd1, FN_MARK_FINAL = 3'd2,
		FN_APPEND = 3'd3, FN_STEP = 3'd4, FN_READ = 3'd5
	} func_t;

	localparam logic [2:0] ST_RUN = 3'd0;
	localparam logic [2:0] ST_ACCEPT = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_EDGE = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	localparam logic CFG_INITIAL_STATE = 1'b0;
	localparam logic CFG_BLANK_SYMBOL = 1'b1;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] from_state;
		logic [7:0] read_symbol;
		logic [7:0] to_state;
		logic [7:0] write_symbol;
		logic move_right;
		logic [11:0] cell_address;
	} in_word_t;

	typedef struct packed {
		logic [2:0] run_status;
		logic [7:0] machine_state;
		logic [11:0] head_index;
		logic [11:0] leftmost_cell;
		logic [11:0] rightmost_cell;
		logic [7:0] cell_symbol;
		logic [31:0] step_count;
	} out_word_t;

	typedef struct packed {
		logic [7:0] from_state;
		logic [7:0] read_symbol;
		logic [7:0] to_state;
		logic [7:0] write_symbol;
		logic move_right;
	} rule_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic clr_start;
		logic clr_write;
		logic add_rule;
		logic mark_final;
		logic append;
		logic step_begin;
		logic scan_read;
		logic scan_next;
		logic fire;
		logic reject;
		logic tape_read_addr;
		logic capture_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic halted;
		logic final_hit;
		logic scan_end;
		logic rule_hit;
	} dp_sts_t;
endpackage

>>> rtl/core/tmse_datapath.sv
// ---------------------------------------------------------------------------
// tmse_datapath
// tape memory, rule memory, final marks and machine registers
// ---------------------------------------------------------------------------
module tmse_datapath (
	input  logic clk,
	input  logic arst_n,
	input  tmse_pkg::in_word_t in_word,
	input  logic [7:0] initial_state_q,
	input  logic [7:0] blank_symbol_q,
	input  tmse_pkg::dp_cmd_t cmd,
	output tmse_pkg::dp_sts_t sts,
	output tmse_pkg::out_word_t out_word
);
	import tmse_pkg::*;

	logic [7:0] tape_mem [TAPE_CELLS];
	rule_t rule_mem [RULE_SLOTS];
	logic [STATE_COUNT-1:0] final_q;

	in_word_t item_q;
	logic [RULE_AW:0] rule_count_q;
	logic [RULE_AW:0] scan_q;
	logic [TAPE_AW-1:0] clr_addr_q;
	logic [7:0] state_q;
	logic [TAPE_AW-1:0] head_q, left_q, right_q;
	logic [TAPE_AW:0] in_len_q;
	logic [31:0] steps_q;
	logic [2:0] halt_q;
	logic ignored_q;
	logic [7:0] tape_rd_q;
	logic [7:0] sym_q;
	rule_t rule_rd_q;
	logic [TAPE_AW-1:0] tape_waddr;
	logic [7:0] tape_wdata;
	logic tape_we;
	logic [TAPE_AW-1:0] tape_raddr;
	logic [TAPE_AW:0] app_pos;
	logic [RULE_AW-1:0] rule_raddr;

	assign app_pos = {1'b0, TAPE_MID} + in_len_q;

	// read ahead so the rule word lines up with the scan index
	assign rule_raddr = cmd.scan_next ? scan_q[RULE_AW-1:0] + 1'b1 : scan_q[RULE_AW-1:0];

	always_comb begin
		tape_we = 1'b0;
		tape_waddr = clr_addr_q;
		tape_wdata = blank_symbol_q;
		if (cmd.clr_write) begin
			tape_we = 1'b1;
		end else if (cmd.append && !app_pos[TAPE_AW]) begin
			tape_we = 1'b1;
			tape_waddr = app_pos[TAPE_AW-1:0];
			tape_wdata = item_q.read_symbol;
		end else if (cmd.fire) begin
			tape_we = 1'b1;
			tape_waddr = head_q;
			tape_wdata = rule_rd_q.write_symbol;
		end
		tape_raddr = cmd.tape_read_addr ? item_q.cell_address[TAPE_AW-1:0] : head_q;
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_waddr] <= tape_wdata;
		end
		tape_rd_q <= tape_mem[tape_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_rule && !rule_count_q[RULE_AW]) begin
			rule_mem[rule_count_q[RULE_AW-1:0]] <= '{item_q.from_state,
				item_q.read_symbol, item_q.to_state, item_q.write_symbol,
				item_q.move_right};
		end
		rule_rd_q <= rule_mem[rule_raddr];
	end

	assign sts.clr_done = (clr_addr_q == TAPE_LAST);
	assign sts.halted = (halt_q != ST_RUN);
	assign sts.final_hit = final_q[state_q];
	assign sts.scan_end = (scan_q >= rule_count_q);
	assign sts.rule_hit = (rule_rd_q.from_state == state_q) &&
		(rule_rd_q.read_symbol == sym_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
			final_q <= '0;
			state_q <= '0;
			head_q <= TAPE_MID;
			left_q <= TAPE_MID;
			right_q <= TAPE_MID;
			in_len_q <= '0;
			steps_q <= '0;
			halt_q <= ST_RUN;
			ignored_q <= 1'b0;
			scan_q <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.load_item) begin
				ignored_q <= 1'b0;
			end
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
				rule_count_q <= '0;
				final_q <= '0;
				head_q <= TAPE_MID;
				left_q <= TAPE_MID;
				right_q <= TAPE_MID;
				in_len_q <= '0;
				state_q <= initial_state_q;
				steps_q <= '0;
				halt_q <= ST_RUN;
			end
			if (cmd.clr_write) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.add_rule) begin
				if (rule_count_q[RULE_AW]) begin
					ignored_q <= 1'b1;
				end else begin
					rule_count_q <= rule_count_q + 1'b1;
				end
			end
			if (cmd.mark_final) begin
				final_q[item_q.from_state] <= 1'b1;
			end
			if (cmd.append) begin
				if (app_pos[TAPE_AW]) begin
					ignored_q <= 1'b1;
				end else begin
					in_len_q <= in_len_q + 1'b1;
					if (app_pos[TAPE_AW-1:0] > right_q) begin
						right_q <= app_pos[TAPE_AW-1:0];
					end
				end
			end
			if (cmd.step_begin) begin
				scan_q <= '0;
				if (final_q[state_q]) begin
					halt_q <= ST_ACCEPT;
				end
			end
			if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.reject) begin
				halt_q <= ST_REJECT;
			end
			if (cmd.fire) begin
				state_q <= rule_rd_q.to_state;
				if (steps_q != 32'hFFFF_FFFF) begin
					steps_q <= steps_q + 1'b1;
				end
				if (rule_rd_q.move_right) begin
					if (head_q == TAPE_LAST) begin
						halt_q <= ST_EDGE;
					end else begin
						head_q <= head_q + 1'b1;
						if (head_q + 1'b1 > right_q) begin
							right_q <= head_q + 1'b1;
						end
					end
				end else begin
					if (head_q == '0) begin
						halt_q <= ST_EDGE;
					end else begin
						head_q <= head_q - 1'b1;
						if (head_q - 1'b1 < left_q) begin
							left_q <= head_q - 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_word;
		end
		if (cmd.scan_read) begin
			sym_q <= tape_rd_q;
		end
		if (cmd.capture_out) begin
			out_word.run_status <= ignored_q ? ST_IGNORED : halt_q;
			out_word.machine_state <= state_q;
			out_word.head_index <= head_q;
			out_word.leftmost_cell <= left_q;
			out_word.rightmost_cell <= right_q;
			out_word.cell_symbol <= tape_rd_q;
			out_word.step_count <= steps_q;
		end
	end
endmodule

>>> rtl/core/tmse_controller.sv
// ---------------------------------------------------------------------------
// tmse_controller
// sequences clear sweep, rule scan and result handshake
// ---------------------------------------------------------------------------
module tmse_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] in_func,
	output logic out_valid,
	input  logic out_stall,
	input  tmse_pkg::dp_sts_t sts,
	output tmse_pkg::dp_cmd_t cmd
);
	import tmse_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_CLEAR, S_STEP, S_SCAN_RD, S_SCAN_CHK,
		S_RD_TAPE, S_RD_WAIT, S_OUT
	} state_t;

	state_t state_q;
	logic [2:0] func_q;
	logic accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.load_item = accept;
		case (state_q)
			S_DECODE: begin
				case (func_q)
					FN_CLEAR: cmd.clr_start = 1'b1;
					FN_ADD_RULE: cmd.add_rule = 1'b1;
					FN_MARK_FINAL: cmd.mark_final = 1'b1;
					FN_APPEND: cmd.append = 1'b1;
					FN_STEP: cmd.step_begin = !sts.halted;
					default: ;
				endcase
			end
			S_CLEAR: cmd.clr_write = 1'b1;
			S_SCAN_RD: cmd.scan_read = 1'b1;
			S_SCAN_CHK: begin
				if (sts.scan_end) begin
					cmd.reject = 1'b1;
				end else if (sts.rule_hit) begin
					cmd.fire = 1'b1;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_RD_TAPE: cmd.tape_read_addr = (func_q == FN_READ);
			S_RD_WAIT: cmd.capture_out = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= FN_CLEAR;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= in_func;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (func_q == FN_CLEAR) begin
						state_q <= S_CLEAR;
					end else if (func_q == FN_STEP && !sts.halted && !sts.final_hit) begin
						state_q <= S_STEP;
					end else begin
						state_q <= S_RD_TAPE;
					end
				end
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= S_RD_TAPE;
					end
				end
				S_STEP: state_q <= S_SCAN_RD;
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (sts.scan_end || sts.rule_hit) begin
						state_q <= S_RD_TAPE;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_RD_TAPE: state_q <= S_RD_WAIT;
				S_RD_WAIT: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/turing_machine_step_engine_top.sv
// ---------------------------------------------------------------------------
// turing_machine_step_engine_top
// single-tape turing machine engine with a 4096-cell tape and 256 rule slots
// ---------------------------------------------------------------------------
// One word in, one word out, one item at a time. Loads and cell reads pass
// through decode, tape read and read wait before the output handshake. A
// clear sweeps the tape one cell a cycle. A step scans the rule memory one
// rule a cycle until the first match or the end of the rules; a step on a
// halted machine or from a final state does no scan. Tape cells read before
// the first clear hold unknown values.
module turing_machine_step_engine_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tmse_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output tmse_pkg::out_word_t out_word,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [7:0] cfg_data
);
	import tmse_pkg::*;

	logic [7:0] initial_state_q;
	logic [7:0] blank_symbol_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	out_word_t dp_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_state_q <= 8'd0;
			blank_symbol_q <= 8'd95;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_STATE: initial_state_q <= cfg_data;
				CFG_BLANK_SYMBOL: blank_symbol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tmse_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_func(in_word.func), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	tmse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word),
		.initial_state_q(initial_state_q), .blank_symbol_q(blank_symbol_q),
		.cmd(cmd), .sts(sts), .out_word(dp_out)
	);

	assign out_word = dp_out;
endmodule

>>> rtl/core/tmse_checker.sv
// ---------------------------------------------------------------------------
// tmse_checker
// port-level checks for the step engine
// ---------------------------------------------------------------------------
`include "turing_machine_step_engine_top_defines.svh"
module tmse_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic out_valid,
	input  logic out_stall,
	input  tmse_pkg::out_word_t out_word
);
	import tmse_pkg::*;

	`TM_ASSERT_IMPL(a_one_at_a_time, clk, arst_n, out_valid, in_stall, "input open while word pending")
	`TM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")
	`TM_ASSERT_IMPL(a_status_range, clk, arst_n, out_valid, out_word.run_status <= ST_IGNORED, "bad status")
	`TM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "accepted two words back to back")
endmodule

bind turing_machine_step_engine_top tmse_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
